>>> src/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when SYNTH is defined
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every rising clock edge outside reset
`define BMCD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be true outside reset
`define BMCD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define BMCD_ASSERT(lbl, clk, rstn, prop, msg)
`define BMCD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

>>> src/bmcd_pkg.sv
// -----------------------------------------------------------------------------
// bmcd_pkg
// types and constants shared by the binary map corner detector
// -----------------------------------------------------------------------------
`default_nettype none

package bmcd_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] FRAME_COLS_RST = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_ROWS_RST = CFG_W'(480);
  localparam logic [CFG_W-1:0] SIZE_MIN       = CFG_W'(2);
  localparam logic [CFG_W-1:0] COLS_MAX       = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] ROWS_MAX       = CFG_W'(MAX_ROWS);

  // result queue
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COLS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               corner_valid;
    logic [COORD_W-1:0] corner_x;
    logic [COORD_W-1:0] corner_y;
    logic               frame_end;
  } corner_res_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } fifo_stat_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/bmcd_if.sv
// -----------------------------------------------------------------------------
// bmcd_if
// valid/ready channels of the corner detector: pixels, results, configuration
// -----------------------------------------------------------------------------
`default_nettype none

interface pixel_if import bmcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface corner_if import bmcd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               corner_valid;
  logic [COORD_W-1:0] corner_x;
  logic [COORD_W-1:0] corner_y;
  logic               frame_end;

  modport source (output valid, output corner_valid, output corner_x,
                  output corner_y, output frame_end, input ready);
  modport sink   (input valid, input corner_valid, input corner_x,
                  input corner_y, input frame_end, output ready);
endinterface

interface cfg_if import bmcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] addr;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> src/bmcd_ram.sv
// -----------------------------------------------------------------------------
// bmcd_ram
// generic single-clock ram, one write port and one registered read port
// -----------------------------------------------------------------------------
`default_nettype none

module bmcd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/bmcd_out_fifo.sv
// -----------------------------------------------------------------------------
// bmcd_out_fifo
// small result queue that decouples the detector pipeline from the sink
// -----------------------------------------------------------------------------
`default_nettype none

module bmcd_out_fifo import bmcd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  corner_res_t     push_data_i,
  output fifo_stat_t      stat_o,
  corner_if.source        out_o
);

  corner_res_t          entry_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [OUT_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [OUT_CNT_W-1:0] count_q, count_d;
  logic                 pop;
  corner_res_t          head;

  assign pop  = out_o.valid && out_o.ready;
  assign head = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + OUT_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + OUT_CNT_W'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_o.valid        = (count_q != '0);
  assign out_o.corner_valid = head.corner_valid;
  assign out_o.corner_x     = head.corner_x;
  assign out_o.corner_y     = head.corner_y;
  assign out_o.frame_end    = head.frame_end;

  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

>>> src/binary_map_corner_detect.sv
// -----------------------------------------------------------------------------
// binary_map_corner_detect
// outer-corner detector over a binary map streamed in raster order
// -----------------------------------------------------------------------------
// Pixels arrive one per transaction, row by row; a zero byte is a set pixel.
// Each pixel closes the 2x2 window whose bottom-right it is, and a window with
// exactly one set pixel yields a corner transaction carrying its x,y. The
// frame's last pixel always yields a transaction with frame_end set. The block
// takes one pixel per clock cycle while the result queue has room: the row
// above lives in a 1024 x 1 line buffer ram that is read once when the pixel
// is taken and written back once in the following cycle. A four-entry result
// queue absorbs output stalls; input ready drops only when that queue and the
// pixel in flight would fill it. The line buffer needs no clearing pass after
// reset. Frame size registers are written through the configuration channel;
// the user must write them only while the stream is idle (not enforced here).
`default_nettype none

`include "assert_macros.svh"

module binary_map_corner_detect import bmcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pixel_if.sink     pix_i,
  corner_if.source  corner_o,
  cfg_if.sink       cfg_i
);

  // configuration
  logic [CFG_W-1:0] cols_q, rows_q;
  logic [CFG_W-1:0] cols_cl, rows_cl;

  // position of the next pixel
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             row_end, frame_end;

  // stage one: pixel whose line buffer read is in flight
  logic             s1_valid_q;
  logic             s1_bit_q;
  logic             s1_frame_end_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;

  // set bits left of the current window column
  logic left_cur_q, left_prev_q;

  logic             pix_accept;
  logic             pix_bit;
  logic [0:0]       line_rdata;
  logic [COL_W-1:0] line_raddr;

  corner_res_t      res;
  logic             res_push;
  logic             corner;
  fifo_stat_t       fifo_stat;
  logic [OUT_CNT_W-1:0] pending;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= FRAME_COLS_RST;
      rows_q <= FRAME_ROWS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.addr))
        REG_FRAME_COLS: cols_q <= cfg_i.data;
        REG_FRAME_ROWS: rows_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cols_cl = clamp_size(cols_q, COLS_MAX);
  assign rows_cl = clamp_size(rows_q, ROWS_MAX);

  // ---------------------------------------------------------------------------
  // input side: position tracking and line buffer read
  // ---------------------------------------------------------------------------
  // room for the pixel in flight plus the one being taken
  assign pending     = fifo_stat.count + OUT_CNT_W'(s1_valid_q);
  assign pix_i.ready = (pending < OUT_CNT_W'(OUT_DEPTH - 1)) ||
                       (pending == OUT_CNT_W'(OUT_DEPTH - 1));
  assign pix_accept  = pix_i.valid && pix_i.ready;
  assign pix_bit     = (pix_i.pixel_value == '0);
  assign line_raddr  = col_q;

  always_comb begin
    row_end   = ({1'b0, col_q} >= (cols_cl - CFG_W'(1)));
    frame_end = row_end && ({1'b0, row_q} >= (rows_cl - CFG_W'(1)));
    col_d     = col_q + COL_W'(1);
    row_d     = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix_accept;
      if (pix_accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      s1_bit_q       <= pix_bit;
      s1_frame_end_q <= frame_end;
      s1_col_q       <= col_q;
      s1_row_q       <= row_q;
    end
  end

  // consecutive pixels never share a column, so the read never meets the
  // write-back of the pixel ahead of it
  bmcd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_bit_q),
    .re_i    (pix_accept),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage one: window evaluation
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cur_q  <= 1'b0;
      left_prev_q <= 1'b0;
    end else if (s1_valid_q) begin
      left_cur_q  <= s1_bit_q;
      left_prev_q <= line_rdata[0];
    end
  end

  always_comb begin
    logic tl_only, tr_only, bl_only, br_only;
    tl_only = 1'b0;
    tr_only = 1'b0;
    bl_only = 1'b0;
    br_only = 1'b0;
    // window bits: top-left, top-right, bottom-left, bottom-right
    case ({left_prev_q, line_rdata[0], left_cur_q, s1_bit_q})
      4'b1000: tl_only = 1'b1;
      4'b0100: tr_only = 1'b1;
      4'b0010: bl_only = 1'b1;
      4'b0001: br_only = 1'b1;
      default: ;
    endcase
    corner = (s1_row_q != '0) && (s1_col_q != '0) &&
             (tl_only || tr_only || bl_only || br_only);

    res.corner_valid = corner;
    res.frame_end    = s1_frame_end_q;
    res.corner_x     = '0;
    res.corner_y     = '0;
    if (corner) begin
      res.corner_x = (tl_only || bl_only) ? s1_col_q : s1_col_q - COL_W'(1);
      res.corner_y = (tl_only || tr_only) ? s1_row_q : s1_row_q - ROW_W'(1);
    end
  end

  assign res_push = s1_valid_q && (corner || s1_frame_end_q);

  bmcd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .stat_o      (fifo_stat),
    .out_o       (corner_o)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `BMCD_ASSERT(a_s1_follows_accept, clk_i, rst_ni, pix_accept |=> s1_valid_q, "stage one missed a pixel")
  `BMCD_ASSERT(a_line_addr_differs, clk_i, rst_ni, (pix_accept && s1_valid_q) |-> (line_raddr != s1_col_q), "line buffer read meets write-back")
  `BMCD_ASSERT_NEVER(a_fifo_room, clk_i, rst_ni, res_push && (fifo_stat.count == OUT_CNT_W'(OUT_DEPTH)) && !(corner_o.valid && corner_o.ready), "result queue overflow")
  `BMCD_ASSERT(a_no_corner_zero, clk_i, rst_ni, (corner_o.valid && !corner_o.corner_valid) |-> (corner_o.corner_x == '0 && corner_o.corner_y == '0 && corner_o.frame_end), "empty result not a clean frame end")
  `BMCD_ASSERT(a_left_tracks, clk_i, rst_ni, s1_valid_q |=> (left_cur_q == $past(s1_bit_q)), "left bit not updated")

endmodule

`default_nettype wire

>>> tb/binary_map_corner_detect_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// binary_map_corner_detect_tb
// self-checking bench for the binary map corner detector
// -----------------------------------------------------------------------------
// Streams pixel frames through the detector and checks every result transaction
// against a cycle-free corner predictor kept in step with each accepted pixel.
// Covers the reset frame size, a mid-frame shrink, a typed table of hand-worked
// windows, a long output stall and randomized frames of mixed size (undersized
// values clamp), density and truncation, with random gaps on both handshakes.
// -----------------------------------------------------------------------------

module binary_map_corner_detect_tb;
  import bmcd_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RANDOM_ITEMS  = 360;
  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  // window weights of the four pixels
  localparam int W_TL = 1;
  localparam int W_TR = 3;
  localparam int W_BL = 5;
  localparam int W_BR = 7;

  typedef enum logic [1:0] {
    GOLD_PREDICT,
    GOLD_NONE,
    GOLD_GIVEN
  } gold_e;

  typedef enum logic {
    FILL_RANDOM,
    FILL_LATTICE
  } fill_e;

  typedef struct {
    logic [PIX_W-1:0] px;
    gold_e            gold;
    corner_res_t      res;
  } pix_item_t;

  logic clk;
  logic rst_n;

  pixel_if  pix ();
  corner_if res ();
  cfg_if    cfg ();

  binary_map_corner_detect DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .pix_i    (pix),
    .corner_o (res),
    .cfg_i    (cfg)
  );

  // predictor state
  logic [CFG_W-1:0] map_cols = 11'd640;
  logic [CFG_W-1:0] map_rows = 11'd480;
  bit               line_bits [MAX_COLS];
  bit               left_cur;
  bit               left_above;
  int               col_pos;
  int               row_pos;
  int               written_cols;

  corner_res_t corner_exp_q [$];
  pix_item_t   stim_q [$];
  pix_item_t   drv_item;

  bit pix_taken;
  int src_idle_pct;
  int snk_idle_pct;
  int hold_req;
  int hold_served;
  int hold_left;

  int pix_pushed;
  int pix_accepted;
  int n_results;
  int n_corners;
  int n_frame_ends;
  int n_reg_writes;
  int n_in_stalls;
  int err_cnt;
  int stall_cycles;

  pix_item_t directed_px [18] = '{
    // 3x3 frame: top-left, bottom-right and bottom-left single pixels
    '{8'h00, GOLD_NONE,    '0},
    '{8'hff, GOLD_NONE,    '0},
    '{8'h01, GOLD_NONE,    '0},
    '{8'hff, GOLD_NONE,    '0},
    '{8'hff, GOLD_GIVEN,   '{1'b1, 10'd1, 10'd1, 1'b0}},
    '{8'h80, GOLD_PREDICT, '0},
    '{8'hfe, GOLD_NONE,    '0},
    '{8'h00, GOLD_GIVEN,   '{1'b1, 10'd0, 10'd1, 1'b0}},
    '{8'hff, GOLD_GIVEN,   '{1'b1, 10'd2, 10'd1, 1'b1}},
    // 3x3 frame: top-right single pixel, frame closes on a two-pixel window
    '{8'hff, GOLD_NONE,    '0},
    '{8'hff, GOLD_NONE,    '0},
    '{8'h00, GOLD_NONE,    '0},
    '{8'hff, GOLD_NONE,    '0},
    '{8'hff, GOLD_PREDICT, '0},
    '{8'hff, GOLD_GIVEN,   '{1'b1, 10'd1, 10'd1, 1'b0}},
    '{8'h00, GOLD_NONE,    '0},
    '{8'h00, GOLD_PREDICT, '0},
    '{8'h00, GOLD_GIVEN,   '{1'b0, 10'd0, 10'd0, 1'b1}}
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  task automatic predict_pixel(input logic [PIX_W-1:0] px, output bit hit,
                               output corner_res_t r);
    int  cols;
    int  rows;
    int  wsum;
    bit  px_set;
    bit  above;
    bit  corner;
    bit  row_done;
    bit  frame_done;
    cols = (map_cols < 2) ? 2 : (map_cols > MAX_COLS) ? MAX_COLS : int'(map_cols);
    rows = (map_rows < 2) ? 2 : (map_rows > MAX_ROWS) ? MAX_ROWS : int'(map_rows);
    px_set = (px == '0);
    above  = line_bits[col_pos];
    corner = 1'b0;
    r      = '0;
    if (row_pos >= 1 && col_pos >= 1) begin
      wsum = W_TL * int'(left_above) + W_TR * int'(above)
           + W_BL * int'(left_cur) + W_BR * int'(px_set);
      corner = 1'b1;
      case (wsum)
        W_TL: begin
          r.corner_x = COORD_W'(col_pos);
          r.corner_y = COORD_W'(row_pos);
        end
        W_TR: begin
          r.corner_x = COORD_W'(col_pos - 1);
          r.corner_y = COORD_W'(row_pos);
        end
        W_BL: begin
          r.corner_x = COORD_W'(col_pos);
          r.corner_y = COORD_W'(row_pos - 1);
        end
        W_BR: begin
          r.corner_x = COORD_W'(col_pos - 1);
          r.corner_y = COORD_W'(row_pos - 1);
        end
        default: corner = 1'b0;
      endcase
    end
    line_bits[col_pos] = px_set;
    if (col_pos + 1 > written_cols) written_cols = col_pos + 1;
    left_above = above;
    left_cur   = px_set;
    // a shrunk size ends the row or frame at once
    row_done   = (col_pos >= cols - 1);
    frame_done = row_done && (row_pos >= rows - 1);
    if (row_done) begin
      col_pos = 0;
      row_pos = frame_done ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    r.corner_valid = corner;
    r.frame_end    = frame_done;
    hit = corner || frame_done;
  endtask

  task automatic check_result();
    corner_res_t e;
    n_results++;
    if (res.corner_valid) n_corners++;
    if (res.frame_end) n_frame_ends++;
    if (corner_exp_q.size() == 0) begin
      $error("unexpected result transaction: valid=%0d x=%0d y=%0d end=%0d",
             res.corner_valid, res.corner_x, res.corner_y, res.frame_end);
      err_cnt++;
    end else begin
      e = corner_exp_q.pop_front();
      if (res.corner_valid !== e.corner_valid) begin
        $error("corner_valid: expected %0d, got %0d", e.corner_valid, res.corner_valid);
        err_cnt++;
      end
      if (res.corner_x !== e.corner_x) begin
        $error("corner_x: expected %0d, got %0d", e.corner_x, res.corner_x);
        err_cnt++;
      end
      if (res.corner_y !== e.corner_y) begin
        $error("corner_y: expected %0d, got %0d", e.corner_y, res.corner_y);
        err_cnt++;
      end
      if (res.frame_end !== e.frame_end) begin
        $error("frame_end: expected %0d, got %0d", e.frame_end, res.frame_end);
        err_cnt++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: sample all handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit          hit;
    bit          res_taken;
    bit          cfg_taken;
    corner_res_t r;
    if (rst_n) begin
      pix_taken = pix.valid && pix.ready;
      res_taken = res.valid && res.ready;
      cfg_taken = cfg.valid && cfg.ready;
      if (pix.valid && !pix.ready) n_in_stalls++;
      if (cfg_taken) begin
        n_reg_writes++;
        case (cfg.addr)
          REG_FRAME_COLS: map_cols = cfg.data;
          REG_FRAME_ROWS: map_rows = cfg.data;
          default: ;
        endcase
      end
      if (pix_taken) begin
        pix_accepted++;
        predict_pixel(pix.pixel_value, hit, r);
        case (drv_item.gold)
          GOLD_PREDICT: if (hit) corner_exp_q = {corner_exp_q, r};
          GOLD_GIVEN:   corner_exp_q = {corner_exp_q, drv_item.res};
          default: ;
        endcase
      end
      if (res_taken) check_result();
      if (pix_taken || res_taken || cfg_taken) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, corner_exp_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers: change at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
    end else if (!pix.valid || pix_taken) begin
      if (stim_q.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        drv_item = stim_q.pop_front();
        pix.valid       <= 1'b1;
        pix.pixel_value <= drv_item.px;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_req) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_pixel(input logic [PIX_W-1:0] px, input gold_e gold,
                            input corner_res_t r);
    pix_item_t item;
    item.px   = px;
    item.gold = gold;
    item.res  = r;
    stim_q = {stim_q, item};
    pix_pushed++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.addr  <= idx;
    cfg.data  <= CFG_W'(val);
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // wait for every pixel and result, then let the pipeline settle
  task automatic wait_idle();
    while (pix_accepted != pix_pushed || corner_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // far_corner plants a lone top-left pixel in the last window of the frame
  task automatic send_frame(input int cols, input int rows, input int count,
                            input fill_e fill, input int density, input bit far_corner);
    int               r;
    int               c;
    logic [PIX_W-1:0] px;
    for (int i = 0; i < count; i++) begin
      r = i / cols;
      c = i % cols;
      if (fill == FILL_LATTICE) begin
        // one set pixel per 2x2 cell makes every window a corner
        px = (r % 2 == 0 && c % 2 == 0) ? 8'h00 : PIX_W'($urandom_range(255, 1));
      end else begin
        px = ($urandom_range(99, 0) < density) ? 8'h00 : PIX_W'($urandom_range(255, 0));
      end
      if (far_corner && r >= rows - 2 && c >= cols - 2) begin
        px = (r == rows - 2 && c == cols - 2) ? 8'h00 : 8'hff;
      end
      push_pixel(px, GOLD_PREDICT, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int    n_random;
    int    raw_c;
    int    raw_r;
    int    cols;
    int    rows;
    int    count;
    fill_e fill;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    res.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.addr        = REG_FRAME_COLS;
    cfg.data        = '0;
    src_idle_pct    = 22;
    snk_idle_pct    = 58;
    n_random        = 0;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: a 640-wide first row puts the lone pixel at (1,1)
    for (int i = 0; i < 641; i++) push_pixel(8'hff, GOLD_PREDICT, '0);
    push_pixel(8'h00, GOLD_PREDICT, '0);
    wait_idle();
    // shrink mid-frame so the next pixel closes the frame
    write_reg(REG_FRAME_ROWS, 2);
    write_reg(REG_FRAME_COLS, 3);
    push_pixel(8'hff, GOLD_PREDICT, '0);
    wait_idle();

    write_reg(REG_FRAME_ROWS, 3);
    foreach (directed_px[i]) push_pixel(directed_px[i].px, directed_px[i].gold,
                                        directed_px[i].res);
    wait_idle();

    // output held off while a corner-dense frame keeps coming
    write_reg(REG_FRAME_COLS, 16);
    write_reg(REG_FRAME_ROWS, 8);
    hold_req++;
    send_frame(16, 8, 128, FILL_LATTICE, 0, 1'b0);
    wait_idle();

    while (n_random < RANDOM_ITEMS) begin
      if (n_random < RANDOM_ITEMS / 3) begin
        src_idle_pct = 22;
        snk_idle_pct = 58;
      end else if (n_random < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 58;
        snk_idle_pct = 22;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case ($urandom_range(9, 0))
        0:       raw_c = $urandom_range(1, 0);
        1, 2:    raw_c = $urandom_range(48, 11);
        default: raw_c = $urandom_range(10, 2);
      endcase
      raw_r = ($urandom_range(9, 0) == 0) ? $urandom_range(1, 0) : $urandom_range(8, 2);
      cols  = (raw_c < 2) ? 2 : raw_c;
      rows  = (raw_r < 2) ? 2 : raw_r;
      // growing mid-frame must not reach line buffer entries never written
      if (row_pos != 0 && cols > written_cols) begin
        cols  = written_cols;
        raw_c = written_cols;
      end
      write_reg(REG_FRAME_COLS, raw_c);
      write_reg(REG_FRAME_ROWS, raw_r);
      count = cols * rows;
      // truncated frame: the next size then lands mid-frame
      if ($urandom_range(7, 0) == 0) count = $urandom_range(count - 1, 1);
      // keep the random part within its pixel budget
      if (count > RANDOM_ITEMS - n_random) count = RANDOM_ITEMS - n_random;
      if ($urandom_range(11, 0) == 0) hold_req++;
      if ($urandom_range(4, 0) == 0) begin
        fill = FILL_LATTICE;
      end else begin
        fill = FILL_RANDOM;
      end
      send_frame(cols, rows, count, fill, $urandom_range(50, 5), $urandom_range(3, 0) == 0);
      n_random += count;
      wait_idle();
    end

    $display("pixels %0d, results %0d (corners %0d, frame ends %0d)",
             pix_accepted, n_results, n_corners, n_frame_ends);
    $display("register writes %0d, output hold-offs %0d, input stall cycles %0d",
             n_reg_writes, hold_req, n_in_stalls);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
